### src/hpe_pkg.sv
// Package for the HPACK Huffman encoder: static code table, widths and shared types.
// No dependencies.
`default_nettype none
package hpe_pkg;

  localparam int ByteW = 8;
  localparam int CodeW = 30;
  localparam int LenW = 5;
  localparam int PendW = 7;
  localparam int CntW = 3;
  localparam int AccW = 37;
  localparam int AccCntW = 6;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0] len;
  } code_ent_t;

  localparam logic [CodeW-1:0] CodeTab [256] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5, 30'hfffffe6,
    30'hfffffe7, 30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea,
    30'h3ffffffd, 30'hfffffeb, 30'hfffffec, 30'hfffffed, 30'hfffffee, 30'hfffffef,
    30'hffffff0, 30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3, 30'hffffff4,
    30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9, 30'hffffffa,
    30'hffffffb, 30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
    30'h7fffd9, 30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde,
    30'hffffeb, 30'h7fffdf, 30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee,
    30'h7fffe1, 30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef, 30'h3fffda, 30'h1fffdd, 30'hfffe9,
    30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde, 30'h7fffea, 30'h3fffdd,
    30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec, 30'h1fffe0,
    30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6,
    30'h7ffff1, 30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
    30'h3fffe8, 30'h1ffffec, 30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3, 30'h3ffffe6,
    30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2, 30'h1fffe4, 30'h1fffe5,
    30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7, 30'h1fffe8,
    30'h7ffff3, 30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
    30'h3ffffea, 30'h7ffff4, 30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe,
    30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [LenW-1:0] LenTab [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
    6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
    5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
    13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
    7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
    15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
    6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

endpackage
`default_nettype wire

### src/hpe_if.sv
// Valid/ready channel interfaces for the encoder input and output.
// Depends on no package.
`default_nettype none
interface hpe_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic is_last;
  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface hpe_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

### src/hpe_lookup.sv
// Input register and code table lookup for one octet.
// Depends on hpe_pkg.
`default_nettype none
module hpe_lookup (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hpe_in_if.sink                     in_ch,
  input  wire logic                  take,
  output logic                       vld,
  output hpe_pkg::code_ent_t         ent,
  output logic                       last
);

  logic [7:0] sym_r;
  logic       last_r;
  logic       vld_r;

  assign in_ch.ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      sym_r <= in_ch.in_byte;
      last_r <= in_ch.is_last;
    end
  end

  assign vld = vld_r;
  assign last = last_r;
  assign ent.code = hpe_pkg::CodeTab[sym_r];
  assign ent.len = hpe_pkg::LenTab[sym_r];

endmodule
`default_nettype wire

### src/hpe_packer.sv
// Bit accumulator that merges codes with leftover bits and emits one byte per beat.
// Depends on hpe_pkg.
`default_nettype none
module hpe_packer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  vld,
  input  hpe_pkg::code_ent_t         ent,
  input  wire logic                  last,
  output logic                       take,
  hpe_out_if.source                  out_ch
);

  localparam int AccW = hpe_pkg::AccW;
  localparam int CW = hpe_pkg::AccCntW;

  // The accumulator holds the code bits still to be sent, right-aligned,
  // with a count. It is loaded only when it has under a byte.
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            last_r, last_nxt;
  logic            ovld_r, ovld_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic            olast_r, olast_nxt;

  logic [AccW-1:0] a;
  logic [CW-1:0]   c;
  logic            l;
  logic            load;
  logic            obuf_free;
  logic [AccW-1:0] sh;
  logic [3:0]      pad;

  always_comb begin
    obuf_free = !ovld_r || out_ch.ready;
    load = obuf_free && (cnt_r < CW'(8)) && !last_r && vld;
    take = load;
    a = acc_r;
    c = cnt_r;
    l = last_r;
    if (load) begin
      a = (acc_r << ent.len) | AccW'(ent.code);
      c = cnt_r + CW'(ent.len);
      l = last;
    end
    acc_nxt = a;
    cnt_nxt = c;
    last_nxt = l;
    ovld_nxt = ovld_r && !out_ch.ready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    sh = a >> (c - CW'(8));
    pad = 4'd8 - {1'b0, c[2:0]};
    if (obuf_free) begin
      if (c >= CW'(8)) begin
        ovld_nxt = 1'b1;
        obyte_nxt = sh[7:0];
        olast_nxt = l && (c == CW'(8));
        cnt_nxt = c - CW'(8);
        if (l && (c == CW'(8))) begin
          last_nxt = 1'b0;
        end
      end else if (l) begin
        ovld_nxt = 1'b1;
        obyte_nxt = 8'((a << pad) | ((AccW'(1) << pad) - AccW'(1)));
        olast_nxt = 1'b1;
        cnt_nxt = '0;
        last_nxt = 1'b0;
      end
    end
    acc_nxt = acc_nxt & ((AccW'(1) << cnt_nxt) - AccW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      last_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      last_r <= last_nxt;
      ovld_r <= ovld_nxt;
    end
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.out_byte = obyte_r;
  assign out_ch.out_last = olast_r;

endmodule
`default_nettype wire

### src/hpack_huffman_encoder_core.sv
// HPACK static Huffman encoder: one octet in, its code packed into bytes out.
// Path: the input register in hpe_lookup, then the packer's one-byte output register.
// Throughput: one output byte per cycle while out_ch.ready is high and input keeps up;
// the one-byte output register drains the bit accumulator, up to five bytes per octet
// (five for a final octet whose four full bytes leave bits for a padded fifth byte).
// Reset: synchronous active-low rst_n empties both registers and the accumulator.
// Depends on hpe_pkg, hpe_if, hpe_lookup and hpe_packer.
`default_nettype none
module hpack_huffman_encoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  hpe_in_if.sink    in_ch,
  hpe_out_if.source out_ch
);

  logic               vld;
  logic               last;
  logic               take;
  hpe_pkg::code_ent_t ent;

  hpe_lookup u_lookup (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .take(take),
    .vld(vld), .ent(ent), .last(last)
  );

  hpe_packer u_packer (
    .clk(clk), .rst_n(rst_n), .vld(vld), .ent(ent), .last(last),
    .take(take), .out_ch(out_ch)
  );

endmodule
`default_nettype wire
